[rtl/core/gei_pkg.sv]
// Shared types and constants of the GPIO edge interrupt controller.
package gei_pkg;

    localparam int WORD_W    = 32;
    localparam int MAX_BANKS = 3;
    localparam int IDX_W     = 7;

    // GPIO0 and GPIO1 have dedicated lines and are kept out of the muxed set
    localparam logic [WORD_W-1:0] DEDICATED_MASK = 32'h0000_0003;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SEL_RISE   = 2'd0,
        SEL_FALL   = 2'd1,
        SEL_STATUS = 2'd2,
        SEL_LEVEL  = 2'd3
    } sel_t;

    typedef struct packed {
        logic              apply;
        func_t             func;
        sel_t              sel;
        logic [WORD_W-1:0] data;
    } bank_cmd_t;

endpackage

[rtl/core/gei_if.sv]
// Valid/ready channel interfaces for items and results.
interface gei_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [1:0]  bank;
    logic [1:0]  reg_sel;
    logic [31:0] wdata;

    modport source (output valid, func, bank, reg_sel, wdata, input ready);
    modport sink   (input valid, func, bank, reg_sel, wdata, output ready);
endinterface

interface gei_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rdata;
    logic        gpio0_irq;
    logic        gpio1_irq;
    logic        irq_muxed;
    logic        pend_valid;
    logic [6:0]  pend_index;

    modport source (output valid, rdata, gpio0_irq, gpio1_irq, irq_muxed, pend_valid,
                    pend_index, input ready);
    modport sink   (input valid, rdata, gpio0_irq, gpio1_irq, irq_muxed, pend_valid,
                    pend_index, output ready);
endinterface

[rtl/core/gpio_edge_irq_controller.sv]
// Top level of the GPIO edge interrupt controller.
//
// Channels: item (sink) carries pin samples and bus accesses; result
// (source) carries one transfer per item: read data, the GPIO0 and GPIO1
// interrupt lines, the muxed line and the lowest pending muxed GPIO number.
// Flow: an accepted item is held in the input register; when it advances,
// the bank registers update and the result register loads and is offered.
// Throughput: one item per cycle while no result waits for ready. The bank
// update and the 96-bit priority encoder on the new edge status sit between
// the input and result registers.
// Reset: all enables, edge status and last levels clear, both stages empty.
// Stall: while a result waits for ready, the input register still holds one
// item and ready drops only once both stages are full; state updates happen
// only when an item moves into the result register.
module gpio_edge_irq_controller #(
    parameter int NUM_BANKS = 3,
    parameter int NUM_GPIO  = 81
) (
    input  logic             clk,
    input  logic             rst_n,
    gei_in_if.sink           item,
    gei_out_if.source        result
);
    import gei_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    func_t             s1_func_reg;
    logic [1:0]        s1_bank_reg;
    sel_t              s1_sel_reg;
    logic [WORD_W-1:0] s1_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] rdata_reg, rdata_next;
    logic              irq0_reg, irq0_next;
    logic              irq1_reg, irq1_next;
    logic              found_reg;
    logic [IDX_W-1:0]  index_reg;

    logic accept;
    logic advance;

    logic [WORD_W-1:0] status_all [NUM_BANKS];
    logic [WORD_W-1:0] read_all   [NUM_BANKS];
    logic [MAX_BANKS*WORD_W-1:0] pend_vec;
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] rd_word;

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign accept     = item.valid && item.ready;

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        bank_cmd_t cmd;

        assign cmd.apply = advance && (s1_bank_reg == 2'(b));
        assign cmd.func  = s1_func_reg;
        assign cmd.sel   = s1_sel_reg;
        assign cmd.data  = s1_data_reg;

        gei_bank #(
            .BANK_IDX (b),
            .NUM_GPIO (NUM_GPIO)
        ) u_bank (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .status_next (status_all[b]),
            .read_word   (read_all[b])
        );
    end

    always_comb
    begin
        pend_vec = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            pend_vec[b*WORD_W +: WORD_W] = status_all[b];
        end
        pend_vec[WORD_W-1:0] = pend_vec[WORD_W-1:0] & ~DEDICATED_MASK;
    end

    gei_prio u_prio (
        .pending (pend_vec),
        .found   (found),
        .index   (index)
    );

    always_comb
    begin
        rd_word = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (s1_bank_reg == 2'(b))
            begin
                rd_word = read_all[b];
            end
        end
        rdata_next = (s1_func_reg == FUNC_READ) ? rd_word : '0;
        irq0_next  = status_all[0][0];
        irq1_next  = status_all[0][1];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func_t'(item.func);
            s1_bank_reg <= item.bank;
            s1_sel_reg  <= sel_t'(item.reg_sel);
            s1_data_reg <= item.wdata;
        end
        if (advance)
        begin
            rdata_reg <= rdata_next;
            irq0_reg  <= irq0_next;
            irq1_reg  <= irq1_next;
            found_reg <= found;
            index_reg <= index;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.rdata      = rdata_reg;
    assign result.gpio0_irq  = irq0_reg;
    assign result.gpio1_irq  = irq1_reg;
    assign result.irq_muxed  = found_reg;
    assign result.pend_valid = found_reg;
    assign result.pend_index = index_reg;

endmodule

[rtl/core/gei_bank.sv]
// Per-bank enable, edge status and last level registers with edge detection.
module gei_bank #(
    parameter int BANK_IDX = 0,
    parameter int NUM_GPIO = 81
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gei_pkg::bank_cmd_t          cmd,
    output logic [gei_pkg::WORD_W-1:0]  status_next,
    output logic [gei_pkg::WORD_W-1:0]  read_word
);
    import gei_pkg::*;

    localparam int BASE  = BANK_IDX * WORD_W;
    localparam int AVAIL = NUM_GPIO - BASE;
    localparam logic [WORD_W-1:0] KEEP =
        (AVAIL <= 0)      ? '0 :
        (AVAIL >= WORD_W) ? '1 :
        WORD_W'((64'd1 << AVAIL) - 64'd1);

    logic [WORD_W-1:0] rise_en_reg, rise_en_next;
    logic [WORD_W-1:0] fall_en_reg, fall_en_next;
    logic [WORD_W-1:0] status_reg;
    logic [WORD_W-1:0] level_reg, level_next;
    logic [WORD_W-1:0] now;
    logic [WORD_W-1:0] rise;
    logic [WORD_W-1:0] fall;

    assign now  = cmd.data & KEEP;
    assign rise = now & ~level_reg;
    assign fall = level_reg & ~now;

    always_comb
    begin
        rise_en_next = rise_en_reg;
        fall_en_next = fall_en_reg;
        status_next  = status_reg;
        level_next   = level_reg;
        if (cmd.apply)
        begin
            unique case (cmd.func)
                FUNC_SAMPLE:
                begin
                    status_next = status_reg |
                                  (((rise & rise_en_reg) | (fall & fall_en_reg)) & KEEP);
                    level_next  = now;
                end
                FUNC_WRITE:
                begin
                    case (cmd.sel)
                        SEL_RISE:   rise_en_next = now;
                        SEL_FALL:   fall_en_next = now;
                        SEL_STATUS: status_next  = status_reg & ~cmd.data;
                        default:    ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            SEL_RISE:   read_word = rise_en_reg & KEEP;
            SEL_FALL:   read_word = fall_en_reg & KEEP;
            SEL_STATUS: read_word = status_reg & KEEP;
            SEL_LEVEL:  read_word = level_reg & KEEP;
            default:    read_word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_en_reg <= '0;
            fall_en_reg <= '0;
            status_reg  <= '0;
            level_reg   <= '0;
        end
        else
        begin
            rise_en_reg <= rise_en_next;
            fall_en_reg <= fall_en_next;
            status_reg  <= status_next;
            level_reg   <= level_next;
        end
    end

endmodule

[rtl/core/gei_prio.sv]
// Priority encoder: lowest set bit of the pending vector.
module gei_prio (
    input  logic [gei_pkg::MAX_BANKS*gei_pkg::WORD_W-1:0] pending,
    output logic                                          found,
    output logic [gei_pkg::IDX_W-1:0]                     index
);
    import gei_pkg::*;

    always_comb
    begin
        found = 1'b0;
        index = '0;
        // scan downwards so the lowest set bit wins
        for (int i = MAX_BANKS*WORD_W - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                found = 1'b1;
                index = IDX_W'(i);
            end
        end
    end

endmodule
